/* sv/ptu_pkg.sv */
// ----------------------------------------------------------------------------
// ptu_pkg
// Shared types, widths and helpers for the particle table Euler update block.
// ----------------------------------------------------------------------------
package ptu_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int VEC_W         = 48;
    localparam int LANE_W        = 16;
    localparam int MAX_PARTICLES_DEF = 64;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [VEC_W-1:0]  pos;
        logic [VEC_W-1:0]  vel;
        logic [VEC_W-1:0]  acc;
        logic [LANE_W-1:0] age;
        logic [LANE_W-1:0] life;
        logic [LANE_W-1:0] scale_b;
        logic [LANE_W-1:0] scale_f;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // lane-wise wrapping add of three packed Q8.8 lanes
    function automatic logic [VEC_W-1:0] vec_add(input logic [VEC_W-1:0] a,
                                                 input logic [VEC_W-1:0] b);
        logic [VEC_W-1:0] r;
        r = '0;
        for (int l = 0; l < 3; l++) begin
            r[l*LANE_W +: LANE_W] = a[l*LANE_W +: LANE_W] + b[l*LANE_W +: LANE_W];
        end
        return r;
    endfunction

endpackage

/* sv/ptu_ram.sv */
// ----------------------------------------------------------------------------
// ptu_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/particle_table_euler_update_top.sv */
// ----------------------------------------------------------------------------
// particle_table_euler_update_top
// Particle table in one RAM with ring head; tick walks, compacts and updates.
// Add: accepted while idle, no result. Tick: per live particle read, update,
// multiply, 32-step divider and write back; a dropped particle is only read and checked.
// The bit-serial divider for the scale interpolation sets the rate.
// Reset empties the table at once; the RAM contents need no clearing.
// ----------------------------------------------------------------------------
module particle_table_euler_update_top #(
    parameter int MAX_PARTICLES = ptu_pkg::MAX_PARTICLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cmd,
    input  logic [ptu_pkg::LANE_W-1:0]  i_life_frames,
    input  logic [ptu_pkg::VEC_W-1:0]   i_start_position,
    input  logic [ptu_pkg::VEC_W-1:0]   i_start_velocity,
    input  logic [ptu_pkg::VEC_W-1:0]   i_acceleration,
    input  logic [ptu_pkg::LANE_W-1:0]  i_scale_begin,
    input  logic [ptu_pkg::LANE_W-1:0]  i_scale_finish,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ptu_pkg::VEC_W-1:0]   o_out_position,
    output logic [ptu_pkg::LANE_W-1:0]  o_out_scale,
    output logic                        o_last
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_MUL, S_DIV, S_EMIT} t_state;

    t_state                         r_state;
    logic [ptu_pkg::ADDR_W-1:0]     r_head;
    logic [ptu_pkg::CNT_W-1:0]      r_count;
    logic [ptu_pkg::CNT_W-1:0]      r_idx;
    logic [ptu_pkg::CNT_W-1:0]      r_kept;
    ptu_pkg::t_entry                r_ent;
    logic                           r_neg;
    logic [16:0]                    r_rem;
    logic [31:0]                    r_quo;
    logic [4:0]                     r_bit;
    logic                           r_pend_v;
    logic [ptu_pkg::VEC_W-1:0]      r_pend_pos;
    logic [ptu_pkg::LANE_W-1:0]     r_pend_scale;
    logic                           r_out_v;
    logic [ptu_pkg::VEC_W-1:0]      r_out_pos;
    logic [ptu_pkg::LANE_W-1:0]     r_out_scale;
    logic                           r_out_last;

    logic                           wr_en;
    logic [ptu_pkg::ADDR_W-1:0]     wr_addr;
    ptu_pkg::t_entry                wr_data;
    ptu_pkg::t_entry                add_ent;
    logic [ptu_pkg::ADDR_W-1:0]     rd_addr;
    ptu_pkg::t_entry                rd_ent;
    ptu_pkg::t_entry                upd_ent;
    logic [ptu_pkg::ENTRY_W-1:0]    rd_raw;
    logic                           slot_free;
    logic                           load_out;
    logic                           in_xfer;
    logic                           full;
    logic [ptu_pkg::VEC_W-1:0]      upd_vel;
    logic [16:0]                    diff;
    logic signed [33:0]             prod;
    logic [33:0]                    prod_mag;
    logic [16:0]                    trial;
    logic [ptu_pkg::LANE_W-1:0]     new_scale;

    assign o_ready   = (r_state == S_IDLE);
    assign in_xfer   = i_valid && o_ready;
    assign slot_free = !r_out_v || i_ready;
    assign full      = r_count >= ptu_pkg::CNT_W'(MAX_PARTICLES);
    assign load_out  = r_pend_v && slot_free &&
                       ((r_state == S_EMIT) || (r_state == S_READ && r_idx == r_count));

    assign add_ent.pos     = i_start_position;
    assign add_ent.vel     = i_start_velocity;
    assign add_ent.acc     = i_acceleration;
    assign add_ent.age     = '0;
    assign add_ent.life    = i_life_frames;
    assign add_ent.scale_b = i_scale_begin;
    assign add_ent.scale_f = i_scale_finish;

    assign rd_ent  = ptu_pkg::t_entry'(rd_raw);
    assign rd_addr = r_head + r_idx[ptu_pkg::ADDR_W-1:0];
    assign upd_vel = ptu_pkg::vec_add(rd_ent.vel, rd_ent.acc);

    always_comb begin
        upd_ent     = rd_ent;
        upd_ent.age = rd_ent.age + 1'b1;
        upd_ent.vel = upd_vel;
        upd_ent.pos = ptu_pkg::vec_add(rd_ent.pos, upd_vel);
    end

    assign diff     = {1'b0, r_ent.scale_f} - {1'b0, r_ent.scale_b};
    assign prod     = $signed(diff) * $signed({1'b0, r_ent.age});
    assign prod_mag = prod[33] ? 34'(-prod) : 34'(prod);
    assign trial    = {r_rem[15:0], r_quo[31]};
    assign new_scale = r_ent.scale_b + (r_neg ? 16'(-r_quo[15:0]) : r_quo[15:0]);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_head - 1'b1;
        wr_data = add_ent;
        if (in_xfer && i_cmd == ptu_pkg::CMD_ADD && !full) begin
            wr_en = 1'b1;
        end else if (r_state == S_EMIT && (!r_pend_v || slot_free)) begin
            wr_en   = 1'b1;
            wr_addr = r_head + r_kept[ptu_pkg::ADDR_W-1:0];
            wr_data = r_ent;
        end
    end

    ptu_ram #(
        .WIDTH (ptu_pkg::ENTRY_W),
        .DEPTH (ptu_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_kept   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_cmd == ptu_pkg::CMD_ADD) begin
                            if (!full) begin
                                r_head  <= r_head - 1'b1;
                                r_count <= r_count + 1'b1;
                            end
                        end else begin
                            r_idx   <= '0;
                            r_kept  <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_idx == r_count) begin
                        if (!r_pend_v) begin
                            r_count <= r_kept;
                            r_state <= S_IDLE;
                        end else if (slot_free) begin
                            r_out_pos   <= r_pend_pos;
                            r_out_scale <= r_pend_scale;
                            r_out_last  <= 1'b1;
                            r_pend_v    <= 1'b0;
                            r_count     <= r_kept;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (rd_ent.age >= rd_ent.life) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end else begin
                        r_ent   <= upd_ent;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_neg   <= prod[33];
                    r_quo   <= prod_mag[31:0];
                    r_rem   <= '0;
                    r_bit   <= '1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (trial >= {1'b0, r_ent.life}) begin
                        r_rem <= trial - {1'b0, r_ent.life};
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_pend_v || slot_free) begin
                        if (r_pend_v) begin
                            r_out_pos   <= r_pend_pos;
                            r_out_scale <= r_pend_scale;
                            r_out_last  <= 1'b0;
                        end
                        r_pend_v     <= 1'b1;
                        r_pend_pos   <= r_ent.pos;
                        r_pend_scale <= new_scale;
                        r_kept       <= r_kept + 1'b1;
                        r_idx        <= r_idx + 1'b1;
                        r_state      <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_v;
    assign o_out_position = r_out_pos;
    assign o_out_scale    = r_out_scale;
    assign o_last         = r_out_last;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ptu_pkg::CNT_W'(MAX_PARTICLES))
        else $error("particle count above capacity");

    a_kept_le_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= r_idx)
        else $error("compaction write index ahead of read index");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_rem < {1'b0, r_ent.life})
        else $error("divider remainder not below divisor");

    a_pend_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && r_pend_v |=> 1'b0)
        else $error("pending result left behind at end of tick");

endmodule

/* tb/sv/tb_particle_table_euler_update_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_table_euler_update_top
// Drives add and tick transfers in random bursts against a stalling receiver,
// predicts every emitted particle from a table model of its own and compares
// position, scale and last mark in order.
// ----------------------------------------------------------------------------
module tb_particle_table_euler_update_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LW = ptu_pkg::LANE_W;
    localparam int VW = ptu_pkg::VEC_W;

    typedef struct packed {
        logic          cmd;
        logic [LW-1:0] life;
        logic [VW-1:0] pos;
        logic [VW-1:0] vel;
        logic [VW-1:0] acc;
        logic [LW-1:0] sb;
        logic [LW-1:0] sf;
    } t_cmd_item;

    typedef struct packed {
        logic [VW-1:0] pos;
        logic [LW-1:0] scale;
        logic          last;
    } t_sprite;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic          i_cmd = 1'b0;
    logic [LW-1:0] i_life_frames = '0;
    logic [VW-1:0] i_start_position = '0;
    logic [VW-1:0] i_start_velocity = '0;
    logic [VW-1:0] i_acceleration = '0;
    logic [LW-1:0] i_scale_begin = '0;
    logic [LW-1:0] i_scale_finish = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic [VW-1:0] o_out_position;
    logic [LW-1:0] o_out_scale;
    logic          o_last;

    particle_table_euler_update_top i_dut (.*);

    always #10 i_clk = ~i_clk;

    t_cmd_item        pending_q[$];
    t_sprite          sprite_q[$];
    ptu_pkg::t_entry  table_m[$];
    int               mismatches = 0;
    int               idle_cycles = 0;
    bit               timed_out = 0;
    int               burst_left = 0;
    int               gap_left = 0;
    int               stall_phase = 0;
    int               n_pending;

    function automatic logic [VW-1:0] lane_sum(logic [VW-1:0] a, logic [VW-1:0] b);
        logic [VW-1:0] r;
        for (int l = 0; l < 3; l++) r[l*16 +: 16] = a[l*16 +: 16] + b[l*16 +: 16];
        return r;
    endfunction

    task automatic apply_item(t_cmd_item it);
        ptu_pkg::t_entry e;
        ptu_pkg::t_entry kept[$];
        longint term;
        if (it.cmd == ptu_pkg::CMD_ADD) begin
            if (table_m.size() >= ptu_pkg::MAX_PARTICLES_DEF) return;
            e.pos = it.pos; e.vel = it.vel; e.acc = it.acc; e.age = '0;
            e.life = it.life; e.scale_b = it.sb; e.scale_f = it.sf;
            table_m.push_front(e);
            return;
        end
        foreach (table_m[i]) if (table_m[i].age < table_m[i].life) kept.push_back(table_m[i]);
        table_m = kept;
        foreach (table_m[i]) begin
            table_m[i].age = LW'(table_m[i].age + 1);
            table_m[i].vel = lane_sum(table_m[i].vel, table_m[i].acc);
            table_m[i].pos = lane_sum(table_m[i].pos, table_m[i].vel);
            term = ((longint'(table_m[i].scale_f) - longint'(table_m[i].scale_b))
                    * longint'(table_m[i].age)) / longint'(table_m[i].life);
            sprite_q.push_back('{pos: table_m[i].pos,
                                 scale: LW'(longint'(table_m[i].scale_b) + term),
                                 last: (i == table_m.size() - 1)});
        end
    endtask

    function automatic logic [VW-1:0] rand_vec();
        return VW'({$urandom(), $urandom()});
    endfunction

    function automatic t_cmd_item rand_item(logic c, int max_life);
        t_cmd_item it;
        it.cmd = c;
        it.life = $urandom_range(0, 9) == 0 ? LW'($urandom()) : LW'($urandom_range(0, max_life));
        it.pos = rand_vec(); it.vel = rand_vec(); it.acc = rand_vec();
        it.sb = LW'($urandom()); it.sf = LW'($urandom());
        return it;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                apply_item(pending_q.pop_front());
            end
            if (!(i_valid && !o_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    i_valid <= 1'b1;
                    {i_cmd, i_life_frames, i_start_position, i_start_velocity,
                     i_acceleration, i_scale_begin, i_scale_finish} <= pending_q[0];
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 8);
                        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_sprite exp_s;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (sprite_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer pos=%h", o_out_position);
                end else begin
                    exp_s = sprite_q.pop_front();
                    if (exp_s !== {o_out_position, o_out_scale, o_last}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp pos=%h scale=%h last=%b got pos=%h scale=%h last=%b",
                                     exp_s.pos, exp_s.scale, exp_s.last,
                                     o_out_position, o_out_scale, o_last);
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 23;
            i_ready <= (stall_phase < 12) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1;
        end
    end

    initial begin
        t_cmd_item it;
        // directed: extremes, zero life, tick of empty table
        it = '{cmd: ptu_pkg::CMD_TICK, default: '0};
        pending_q.push_back(it);
        it = '{ptu_pkg::CMD_ADD, 16'd0, '1, '1, '1, '1, '0};
        pending_q.push_back(it);
        it = '{ptu_pkg::CMD_ADD, 16'hFFFF, '1, '1, '1, '0, '1};
        pending_q.push_back(it);
        it = '{ptu_pkg::CMD_ADD, 16'd1, '0, '0, '0, 16'hFFFF, 16'hFFFF};
        pending_q.push_back(it);
        it = '{ptu_pkg::CMD_ADD, 16'd3, 48'h7FFF_8000_7FFF, 48'h0001_FFFF_0001,
               48'h8000_7FFF_8000, 16'h0100, 16'h0000};
        pending_q.push_back(it);
        for (int k = 0; k < 4; k++) begin
            it = rand_item(ptu_pkg::CMD_TICK, 1); it.life = '1; pending_q.push_back(it);
        end
        // fill the table beyond capacity, then tick
        for (int k = 0; k < 66; k++) pending_q.push_back(rand_item(ptu_pkg::CMD_ADD, 6));
        for (int k = 0; k < 2; k++) pending_q.push_back(rand_item(ptu_pkg::CMD_TICK, 6));
        // random mix, small tables mostly
        for (int k = 0; k < 300; k++)
            pending_q.push_back(rand_item($urandom_range(0, 3) == 0, 8));
        pending_q.push_back(rand_item(ptu_pkg::CMD_TICK, 1));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n_pending = 1;
        while (n_pending != 0 && !timed_out) begin
            @(posedge i_clk);
            n_pending = pending_q.size() + sprite_q.size() + int'(i_valid);
        end
        repeat (200) @(posedge i_clk);
        if (timed_out || mismatches != 0 || sprite_q.size() != 0) $display("simulation failed");
        else $display("simulation ok");
        $finish;
    end
endmodule

/* sim.f */
sv/ptu_pkg.sv
sv/ptu_ram.sv
sv/particle_table_euler_update_top.sv
tb/sv/tb_particle_table_euler_update_top.sv
